/* design/rhs_pkg.sv */
// package for the rail handoff sequencer: item structs, phase, result and
// command codes, opcodes and configuration register indexes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rhs_pkg;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_START  = 2'd1,
        OP_CANCEL = 2'd2,
        OP_RESET  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SRC  = 3'd1,
        PH_EXT  = 3'd2,
        PH_WAIT = 3'd3,
        PH_RET  = 3'd4,
        PH_DST  = 3'd5,
        PH_DONE = 3'd6,
        PH_ERR  = 3'd7
    } t_phase;

    typedef enum logic [3:0] {
        RC_OK        = 4'd0,
        RC_ESTOP     = 4'd1,
        RC_TIMEOUT   = 4'd2,
        RC_SENSOR    = 4'd3,
        RC_MOVEMENT  = 4'd4,
        RC_VALVE     = 4'd5,
        RC_PARAMS    = 4'd6,
        RC_NOTREADY  = 4'd7,
        RC_COLLISION = 4'd8,
        RC_MISSING   = 4'd9
    } t_rc;

    typedef enum logic [2:0] {
        CMD_NONE       = 3'd0,
        CMD_R1_HANDOFF = 3'd1,
        CMD_R2_HANDOFF = 3'd2,
        CMD_EXTEND     = 3'd3,
        CMD_RETRACT    = 3'd4,
        CMD_R2_CELL3   = 3'd5,
        CMD_R1_CELL1   = 3'd6,
        CMD_R1_CELL2   = 3'd7
    } t_cmd;

    // direction and destination codes
    localparam logic       DIR_R1_TO_R2    = 1'b0;
    localparam logic       DIR_R2_TO_R1    = 1'b1;
    localparam logic [1:0] DEST_CELL1      = 2'd0;
    localparam logic [1:0] DEST_CELL2      = 2'd1;
    localparam logic [1:0] DEST_STAGE_AREA = 2'd2;
    localparam logic [1:0] DEST_CELL3      = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_PHASE_TO     = 2'd0;
    localparam logic [1:0] CFG_PHASE_TO_WC3 = 2'd1;
    localparam logic [1:0] CFG_SENSOR_TO    = 2'd2;

    localparam int unsigned CFG_W = 20;

    localparam logic [CFG_W-1:0] PHASE_TO_RST     = 20'd30000;
    localparam logic [CFG_W-1:0] PHASE_TO_WC3_RST = 20'd60000;
    localparam logic [CFG_W-1:0] SENSOR_TO_RST    = 20'd5000;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        direction;
        logic [1:0]  destination;
        logic        estop_active;
        logic [2:0]  readiness;
        logic [3:0]  labware_sensors;
        logic [1:0]  cylinder_position;
        logic        move_done;
        logic [2:0]  valve_status;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [3:0] result_code;
        logic [2:0] phase;
        logic       in_progress;
        logic [2:0] command;
        logic       carrying_labware;
    } t_out_item;

endpackage

`default_nettype wire

/* design/rail_handoff_sequencer_core.sv */
// rail handoff sequencer: input register, one pass of phase logic, result register
// depends on rhs_pkg
//
// usage: each input item carries one opcode (update tick, start, cancel,
// reset) together with a snapshot of time and sensors; each item gives
// exactly one result item with the result code, the phase after the item,
// the carriage or cylinder command for this item and the carry flag.
// the input channel (i_in_valid / o_in_stall) feeds an input register, the
// phase logic runs between that register and the result register, and the
// output channel (o_out_valid / i_out_stall) is driven from the result
// register. the phase logic result goes into the result register from the
// item in the input register; one item is taken every cycle while the
// receiver does not stall.
// when the receiver stalls, the result holds and the input register fills;
// after that o_in_stall rises until the result is taken.
// the user must write timeouts (i_cfg_we / i_cfg_idx / i_cfg_wdata) only while
// the block is idle (not enforced); an index beyond CFG_SENSOR_TO is ignored.
// synchronous reset (i_rst_n low) empties both registers, puts the phase at
// idle and loads the default timeouts.
`timescale 1ns / 1ps
`default_nettype none

module rail_handoff_sequencer_core
    import rhs_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output t_out_item        o_out_item,
    input  wire              i_cfg_we,
    input  wire [1:0]        i_cfg_idx,
    input  wire [CFG_W-1:0]  i_cfg_wdata
);

    logic             r_in_valid;
    t_in_item         r_in_item;
    logic             r_out_valid;
    t_out_item        r_out_item;
    t_out_item        n_out_item;

    logic [CFG_W-1:0] r_phase_to;
    logic [CFG_W-1:0] r_phase_to_wc3;
    logic [CFG_W-1:0] r_sensor_to;

    t_phase           r_phase,  n_phase;
    t_rc              r_last,   n_last;
    logic             r_dir,    n_dir;
    logic [1:0]       r_dest,   n_dest;
    logic [31:0]      r_start,  n_start;
    logic             r_long,   n_long;

    logic             out_ready;
    logic             proc;
    logic             in_ready;

    logic [31:0]      elapsed;
    logic [CFG_W-1:0] phase_lim;
    logic             phase_exp;
    logic             sensor_exp;
    logic             active;
    logic             c1, c2, c3, ho, r1, r2, bad, src_seen;
    logic             cyl_ext, cyl_ret;
    t_rc              rc;
    t_cmd             cmd;
    logic             carry;

    assign out_ready   = !r_out_valid || !i_out_stall;
    assign proc        = r_in_valid && out_ready;
    assign in_ready    = !r_in_valid || proc;
    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign elapsed    = r_in_item.now_ms - r_start;
    assign phase_lim  = r_long ? r_phase_to_wc3 : r_phase_to;
    assign phase_exp  = elapsed >= {12'd0, phase_lim};
    assign sensor_exp = elapsed >= {12'd0, r_sensor_to};
    assign active     = (r_phase == PH_SRC) || (r_phase == PH_EXT) || (r_phase == PH_WAIT)
                        || (r_phase == PH_RET) || (r_phase == PH_DST);

    assign c1      = r_in_item.labware_sensors[0];
    assign c2      = r_in_item.labware_sensors[1];
    assign c3      = r_in_item.labware_sensors[2];
    assign ho      = r_in_item.labware_sensors[3];
    assign r1      = c1 || c2;
    assign r2      = c3 || ho;
    assign cyl_ext = r_in_item.cylinder_position[0];
    assign cyl_ret = r_in_item.cylinder_position[1];

    // collision check for a start
    always_comb begin
        bad = (r1 && r2) || (r_in_item.direction == DIR_R1_TO_R2 && !r1)
              || (r_in_item.direction == DIR_R2_TO_R1 && !r2);
        if (!bad) begin
            if (r_in_item.direction == DIR_R2_TO_R1) begin
                if (r_in_item.destination == DEST_CELL1) begin
                    bad = c1;
                end else if (r_in_item.destination == DEST_CELL2) begin
                    bad = c2;
                end else begin
                    bad = 1'b1;
                end
            end else begin
                bad = c3;
            end
        end
    end

    // source carriage still holding labware during transfer verify
    assign src_seen = (r_dir == DIR_R1_TO_R2) ? r1 : c3;

    always_comb begin
        n_phase = r_phase;
        n_last  = r_last;
        n_dir   = r_dir;
        n_dest  = r_dest;
        n_start = r_start;
        n_long  = r_long;
        rc      = RC_OK;
        cmd     = CMD_NONE;
        carry   = 1'b0;
        case (t_op'(r_in_item.opcode))
            OP_START: begin
                if ((r_in_item.direction == DIR_R1_TO_R2
                        && r_in_item.destination != DEST_CELL3)
                    || (r_in_item.direction == DIR_R2_TO_R1
                        && r_in_item.destination == DEST_CELL3)) begin
                    n_last = RC_PARAMS;
                    rc     = RC_PARAMS;
                end else if (r_phase != PH_IDLE) begin
                    rc = RC_NOTREADY;
                end else if (r_in_item.estop_active || r_in_item.readiness != 3'b111) begin
                    n_last = RC_NOTREADY;
                    rc     = RC_NOTREADY;
                end else if (bad) begin
                    n_last = RC_COLLISION;
                    rc     = RC_COLLISION;
                end else begin
                    n_dir   = r_in_item.direction;
                    n_dest  = r_in_item.destination;
                    n_long  = (r_in_item.destination == DEST_CELL3);
                    n_phase = PH_SRC;
                    n_start = r_in_item.now_ms;
                end
            end
            OP_CANCEL: begin
                if (r_phase != PH_IDLE) begin
                    n_phase = PH_IDLE;
                    n_last  = RC_OK;
                    if (cyl_ext) begin
                        cmd = CMD_RETRACT;
                    end
                end
            end
            OP_RESET: begin
                n_phase = PH_IDLE;
                n_last  = RC_OK;
                n_start = 32'd0;
            end
            default: begin
                if (active && phase_exp) begin
                    n_phase = PH_ERR;
                    n_last  = RC_TIMEOUT;
                end else if (r_in_item.estop_active) begin
                    n_phase = PH_ERR;
                    n_last  = RC_ESTOP;
                end else begin
                    case (r_phase)
                        PH_SRC: begin
                            if (r_dir == DIR_R1_TO_R2) begin
                                cmd   = CMD_R1_HANDOFF;
                                carry = r1;
                            end else begin
                                cmd   = CMD_R2_HANDOFF;
                                carry = r2;
                            end
                            if (r_in_item.move_done) begin
                                n_phase = PH_EXT;
                                n_start = r_in_item.now_ms;
                            end
                        end
                        PH_EXT: begin
                            cmd = CMD_EXTEND;
                            if (r_in_item.valve_status != 3'd0) begin
                                n_phase = PH_ERR;
                                n_last  = RC_VALVE;
                            end else if (cyl_ext) begin
                                n_phase = PH_WAIT;
                                n_start = r_in_item.now_ms;
                            end
                        end
                        PH_WAIT: begin
                            if (sensor_exp) begin
                                if (cyl_ext) begin
                                    cmd = CMD_RETRACT;
                                end
                                n_phase = PH_ERR;
                                n_last  = RC_SENSOR;
                            end else if (ho && !src_seen) begin
                                n_phase = PH_RET;
                                n_start = r_in_item.now_ms;
                            end else if (!ho && !src_seen) begin
                                n_phase = PH_ERR;
                                n_last  = RC_MISSING;
                            end else begin
                                n_phase = PH_ERR;
                                n_last  = RC_SENSOR;
                            end
                        end
                        PH_RET: begin
                            cmd = CMD_RETRACT;
                            if (r_in_item.valve_status != 3'd0) begin
                                n_phase = PH_ERR;
                                n_last  = RC_VALVE;
                            end else if (cyl_ret) begin
                                n_phase = PH_DST;
                                n_start = r_in_item.now_ms;
                            end
                        end
                        PH_DST: begin
                            // rail two to staging has no carriage move and waits out the timeout
                            if (r_dir == DIR_R1_TO_R2) begin
                                cmd = CMD_R2_CELL3;
                            end else if (r_dest == DEST_CELL1) begin
                                cmd = CMD_R1_CELL1;
                            end else if (r_dest == DEST_CELL2) begin
                                cmd = CMD_R1_CELL2;
                            end
                            if (cmd != CMD_NONE) begin
                                carry = 1'b1;
                                if (r_in_item.move_done) begin
                                    n_phase = PH_DONE;
                                    n_last  = RC_OK;
                                end
                            end
                        end
                        PH_DONE: begin
                            n_phase = PH_IDLE;
                        end
                        default: begin
                        end
                    endcase
                end
                rc = (n_phase == PH_ERR) ? n_last : RC_OK;
            end
        endcase

        n_out_item.result_code      = rc;
        n_out_item.phase            = n_phase;
        n_out_item.in_progress      = (n_phase == PH_SRC) || (n_phase == PH_EXT)
                                      || (n_phase == PH_WAIT) || (n_phase == PH_RET)
                                      || (n_phase == PH_DST);
        n_out_item.command          = cmd;
        n_out_item.carrying_labware = carry;
    end

    // handshake and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_phase        <= PH_IDLE;
            r_last         <= RC_OK;
            r_dir          <= DIR_R1_TO_R2;
            r_dest         <= DEST_CELL3;
            r_start        <= 32'd0;
            r_long         <= 1'b0;
            r_phase_to     <= PHASE_TO_RST;
            r_phase_to_wc3 <= PHASE_TO_WC3_RST;
            r_sensor_to    <= SENSOR_TO_RST;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
            if (proc) begin
                r_phase <= n_phase;
                r_last  <= n_last;
                r_dir   <= n_dir;
                r_dest  <= n_dest;
                r_start <= n_start;
                r_long  <= n_long;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PHASE_TO:     r_phase_to     <= i_cfg_wdata;
                    CFG_PHASE_TO_WC3: r_phase_to_wc3 <= i_cfg_wdata;
                    CFG_SENSOR_TO:    r_sensor_to    <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (proc) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

`default_nettype wire

/* design/rhs_checker.sv */
// port-level checks for the rail handoff sequencer, bound to the core module
// depends on rhs_pkg and rail_handoff_sequencer_core
`timescale 1ns / 1ps
`default_nettype none

module rhs_checker
    import rhs_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              o_out_valid,
    input  wire              i_out_stall,
    input  t_out_item        o_out_item
);

    // in-progress flag agrees with the reported phase
    a_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.in_progress ==
            ((o_out_item.phase == PH_SRC) || (o_out_item.phase == PH_EXT)
             || (o_out_item.phase == PH_WAIT) || (o_out_item.phase == PH_RET)
             || (o_out_item.phase == PH_DST))))
        else $error("in_progress does not match phase");

    // carry flag only goes with a carriage move
    a_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.carrying_labware) |->
            ((o_out_item.command == CMD_R1_HANDOFF) || (o_out_item.command == CMD_R2_HANDOFF)
             || (o_out_item.command == CMD_R2_CELL3) || (o_out_item.command == CMD_R1_CELL1)
             || (o_out_item.command == CMD_R1_CELL2)))
        else $error("carry flag without carriage move");

    // extend command leaves the block in extend, transfer verify or error
    a_extend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.command == CMD_EXTEND) |->
            ((o_out_item.phase == PH_EXT) || (o_out_item.phase == PH_WAIT)
             || (o_out_item.phase == PH_ERR)))
        else $error("extend command in unexpected phase");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind rail_handoff_sequencer_core rhs_checker u_rhs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

/* verif/tb_top.sv */
// self-checking bench for rail_handoff_sequencer_core: queued handoff items, a
// clocked driver and monitor, and an in-bench predictor of the phase sequencer
// depends on rhs_pkg and the core
`timescale 1ns / 1ps

module tb_top;
    import rhs_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    t_in_item         in_item = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_item        out_item;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_idx = CFG_PHASE_TO;
    logic [CFG_W-1:0] cfg_wdata = '0;

    rail_handoff_sequencer_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state and timeout settings
    t_phase           seq_phase = PH_IDLE;
    t_rc              seq_rc = RC_OK;
    logic             seq_dir = DIR_R1_TO_R2;
    logic [1:0]       seq_dest = DEST_CELL3;
    logic [31:0]      seq_t0 = '0;
    logic             seq_long = 1'b0;
    logic [CFG_W-1:0] lim_phase = PHASE_TO_RST;
    logic [CFG_W-1:0] lim_wc3 = PHASE_TO_WC3_RST;
    logic [CFG_W-1:0] lim_sensor = SENSOR_TO_RST;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int        mismatches = 0;
    int        quiet_cycles = 0;
    logic      no_idle = 1'b0;

    // stimulus time base
    logic [31:0] clock_ms;
    int unsigned tick_max;
    int unsigned jump_max;

    function automatic t_out_item predict_handoff(t_in_item it);
        t_out_item   res;
        t_rc         rc;
        t_cmd        cmd;
        logic        carry, near_r1, near_r2, blocked, ho, src, active;
        logic [31:0] elapsed;
        logic [CFG_W-1:0] lim;
        rc = RC_OK;
        cmd = CMD_NONE;
        carry = 1'b0;
        case (it.opcode)
            OP_START: begin
                if ((it.direction == DIR_R1_TO_R2 && it.destination != DEST_CELL3) ||
                    (it.direction == DIR_R2_TO_R1 && it.destination == DEST_CELL3)) begin
                    rc = RC_PARAMS;
                    seq_rc = RC_PARAMS;
                end else if (seq_phase != PH_IDLE) begin
                    rc = RC_NOTREADY;
                end else if (it.estop_active || it.readiness != 3'b111) begin
                    rc = RC_NOTREADY;
                    seq_rc = RC_NOTREADY;
                end else begin
                    near_r1 = |it.labware_sensors[1:0];
                    near_r2 = |it.labware_sensors[3:2];
                    blocked = (near_r1 && near_r2) ||
                              (it.direction == DIR_R1_TO_R2 && !near_r1) ||
                              (it.direction == DIR_R2_TO_R1 && !near_r2);
                    if (!blocked) begin
                        if (it.direction == DIR_R2_TO_R1) begin
                            if (it.destination == DEST_CELL1)
                                blocked = it.labware_sensors[0];
                            else if (it.destination == DEST_CELL2)
                                blocked = it.labware_sensors[1];
                            else
                                blocked = 1'b1;
                        end else begin
                            blocked = it.labware_sensors[2];
                        end
                    end
                    if (blocked) begin
                        rc = RC_COLLISION;
                        seq_rc = RC_COLLISION;
                    end else begin
                        seq_dir = it.direction;
                        seq_dest = it.destination;
                        seq_long = (it.destination == DEST_CELL3);
                        seq_phase = PH_SRC;
                        seq_t0 = it.now_ms;
                    end
                end
            end
            OP_CANCEL: begin
                if (seq_phase != PH_IDLE) begin
                    seq_phase = PH_IDLE;
                    seq_rc = RC_OK;
                    if (it.cylinder_position[0])
                        cmd = CMD_RETRACT;
                end
            end
            OP_RESET: begin
                seq_phase = PH_IDLE;
                seq_rc = RC_OK;
                seq_t0 = '0;
            end
            default: begin
                active = (seq_phase >= PH_SRC) && (seq_phase <= PH_DST);
                lim = seq_long ? lim_wc3 : lim_phase;
                elapsed = it.now_ms - seq_t0;
                if (active && elapsed >= {12'd0, lim}) begin
                    seq_phase = PH_ERR;
                    seq_rc = RC_TIMEOUT;
                end else if (it.estop_active) begin
                    seq_phase = PH_ERR;
                    seq_rc = RC_ESTOP;
                end else begin
                    case (seq_phase)
                        PH_SRC: begin
                            if (seq_dir == DIR_R1_TO_R2) begin
                                cmd = CMD_R1_HANDOFF;
                                carry = |it.labware_sensors[1:0];
                            end else begin
                                cmd = CMD_R2_HANDOFF;
                                carry = |it.labware_sensors[3:2];
                            end
                            if (it.move_done) begin
                                seq_phase = PH_EXT;
                                seq_t0 = it.now_ms;
                            end
                        end
                        PH_EXT: begin
                            cmd = CMD_EXTEND;
                            if (it.valve_status == 3'd0 && it.cylinder_position[0]) begin
                                seq_phase = PH_WAIT;
                                seq_t0 = it.now_ms;
                            end else if (it.valve_status != 3'd0) begin
                                seq_phase = PH_ERR;
                                seq_rc = RC_VALVE;
                            end
                        end
                        PH_WAIT: begin
                            if (elapsed >= {12'd0, lim_sensor}) begin
                                if (it.cylinder_position[0])
                                    cmd = CMD_RETRACT;
                                seq_phase = PH_ERR;
                                seq_rc = RC_SENSOR;
                            end else begin
                                ho = it.labware_sensors[3];
                                src = (seq_dir == DIR_R1_TO_R2) ? |it.labware_sensors[1:0]
                                                                : it.labware_sensors[2];
                                if (ho && !src) begin
                                    seq_phase = PH_RET;
                                    seq_t0 = it.now_ms;
                                end else if (!ho && !src) begin
                                    seq_phase = PH_ERR;
                                    seq_rc = RC_MISSING;
                                end else begin
                                    seq_phase = PH_ERR;
                                    seq_rc = RC_SENSOR;
                                end
                            end
                        end
                        PH_RET: begin
                            cmd = CMD_RETRACT;
                            if (it.valve_status == 3'd0 && it.cylinder_position[1]) begin
                                seq_phase = PH_DST;
                                seq_t0 = it.now_ms;
                            end else if (it.valve_status != 3'd0) begin
                                seq_phase = PH_ERR;
                                seq_rc = RC_VALVE;
                            end
                        end
                        PH_DST: begin
                            if (seq_dir == DIR_R1_TO_R2)
                                cmd = CMD_R2_CELL3;
                            else if (seq_dest == DEST_CELL1)
                                cmd = CMD_R1_CELL1;
                            else if (seq_dest == DEST_CELL2)
                                cmd = CMD_R1_CELL2;
                            // other destinations give no move and sit until the phase timeout
                            if (cmd != CMD_NONE) begin
                                carry = 1'b1;
                                if (it.move_done) begin
                                    seq_phase = PH_DONE;
                                    seq_rc = RC_OK;
                                end
                            end
                        end
                        PH_DONE: begin
                            seq_phase = PH_IDLE;
                        end
                        default: ;
                    endcase
                end
                if (seq_phase == PH_ERR)
                    rc = seq_rc;
            end
        endcase
        res.result_code = rc;
        res.phase = seq_phase;
        res.in_progress = (seq_phase >= PH_SRC) && (seq_phase <= PH_DST);
        res.command = cmd;
        res.carrying_labware = carry;
        return res;
    endfunction

    // stimulus builders

    function automatic logic [31:0] next_ms();
        case ($urandom_range(0, 49))
            0:       clock_ms = $urandom;
            1, 2:    clock_ms += $urandom_range(0, jump_max);
            default: clock_ms += $urandom_range(0, tick_max);
        endcase
        return clock_ms;
    endfunction

    function automatic t_in_item base_item(t_op op);
        t_in_item it;
        it.opcode = op;
        it.direction = 1'($urandom_range(0, 1));
        it.destination = 2'($urandom_range(0, 3));
        it.estop_active = 1'($urandom_range(0, 1));
        it.readiness = 3'($urandom_range(0, 7));
        it.labware_sensors = 4'($urandom_range(0, 15));
        it.cylinder_position = 2'($urandom_range(0, 3));
        it.move_done = 1'($urandom_range(0, 1));
        it.valve_status = 3'($urandom_range(0, 7));
        it.now_ms = next_ms();
        return it;
    endfunction

    // an update tick that now and then turns into another opcode mid-flight
    function automatic t_in_item update_item();
        t_in_item it;
        it = base_item(OP_UPDATE);
        it.estop_active = ($urandom_range(0, 63) == 0);
        if ($urandom_range(0, 39) == 0)
            it.opcode = 2'($urandom_range(1, 3));
        return it;
    endfunction

    function automatic t_in_item start_item(logic dir, logic [1:0] dest, logic [2:0] ready,
                                            logic estop, logic [3:0] sens);
        t_in_item it;
        it = base_item(OP_START);
        it.direction = dir;
        it.destination = dest;
        it.readiness = ready;
        it.estop_active = estop;
        it.labware_sensors = sens;
        return it;
    endfunction

    // one handoff from start to done, with random detours into faults
    task automatic queue_handoff();
        t_in_item   it;
        logic       dir;
        logic [1:0] dest, nz;
        logic [2:0] ready;
        logic [3:0] sens;
        dir = 1'($urandom_range(0, 1));
        nz = 2'($urandom_range(1, 3));
        if (dir == DIR_R1_TO_R2) begin
            dest = DEST_CELL3;
            sens = {2'b00, nz};
        end else begin
            dest = $urandom_range(0, 1) ? DEST_CELL2 : DEST_CELL1;
            sens = {nz, 2'b00};
        end
        if ($urandom_range(0, 11) == 0) begin
            dest = 2'($urandom_range(0, 3));
            sens = 4'($urandom_range(0, 15));
        end
        ready = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(0, 7)) : 3'b111;
        pending_items.push_back(start_item(dir, dest, ready, $urandom_range(0, 31) == 0, sens));

        repeat ($urandom_range(0, 3)) begin
            it = update_item();
            it.move_done = 1'b0;
            pending_items.push_back(it);
        end
        it = update_item();
        it.move_done = 1'b1;
        pending_items.push_back(it);

        repeat ($urandom_range(0, 3)) begin
            it = update_item();
            it.valve_status = 3'd0;
            it.cylinder_position[0] = 1'b0;
            pending_items.push_back(it);
        end
        it = update_item();
        it.valve_status = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
        it.cylinder_position[0] = 1'b1;
        pending_items.push_back(it);

        // labware on the handoff and gone from the source
        it = update_item();
        if ($urandom_range(0, 9) != 0) begin
            it.labware_sensors[3] = 1'b1;
            if (dir == DIR_R1_TO_R2)
                it.labware_sensors[1:0] = 2'b00;
            else
                it.labware_sensors[2] = 1'b0;
        end
        pending_items.push_back(it);

        repeat ($urandom_range(0, 3)) begin
            it = update_item();
            it.valve_status = 3'd0;
            it.cylinder_position[1] = 1'b0;
            pending_items.push_back(it);
        end
        it = update_item();
        it.valve_status = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
        it.cylinder_position[1] = 1'b1;
        pending_items.push_back(it);

        repeat ($urandom_range(0, 3)) begin
            it = update_item();
            it.move_done = 1'b0;
            pending_items.push_back(it);
        end
        it = update_item();
        it.move_done = 1'b1;
        pending_items.push_back(it);

        pending_items.push_back(update_item());
        pending_items.push_back(base_item($urandom_range(0, 2) != 0 ? OP_CANCEL : OP_RESET));
    endtask

    task automatic fill_random(int count);
        int target;
        target = pending_items.size() + count;
        while (pending_items.size() < target) begin
            if ($urandom_range(0, 99) < 85)
                queue_handoff();
            else
                pending_items.push_back(base_item(t_op'($urandom_range(0, 3))));
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timeout(logic [1:0] idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PHASE_TO:     lim_phase = value;
            CFG_PHASE_TO_WC3: lim_wc3 = value;
            CFG_SENSOR_TO:    lim_sensor = value;
            default: ;
        endcase
    endtask

    task automatic set_timeouts(int unsigned phase_ms, int unsigned wc3_ms, int unsigned sensor_ms);
        write_timeout(CFG_PHASE_TO, CFG_W'(phase_ms));
        write_timeout(CFG_PHASE_TO_WC3, CFG_W'(wc3_ms));
        write_timeout(CFG_SENSOR_TO, CFG_W'(sensor_ms));
    endtask

    // driver
    int in_gap = 0;
    int in_idle_pct = 10;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                expected_results.push_back(predict_handoff(in_item));
            if ($urandom_range(0, 299) == 0) begin
                case ($urandom_range(0, 2))
                    0:       in_idle_pct = 0;
                    1:       in_idle_pct = 8;
                    default: in_idle_pct = 30;
                endcase
            end
            if (!in_valid || !in_stall) begin
                if (in_gap != 0 && !no_idle) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() != 0 && !no_idle &&
                             $urandom_range(0, 99) < in_idle_pct) begin
                    in_gap = $urandom_range(0, 8);
                    in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    in_gap = 0;
                    in_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int stall_left = 0;
    int out_stall_pct = 10;

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result item arrived with nothing expected");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("result_code", 32'(want.result_code),
                                32'(out_item.result_code));
                    check_field("phase", 32'(want.phase), 32'(out_item.phase));
                    check_field("in_progress", 32'(want.in_progress),
                                32'(out_item.in_progress));
                    check_field("command", 32'(want.command), 32'(out_item.command));
                    check_field("carrying_labware", 32'(want.carrying_labware),
                                32'(out_item.carrying_labware));
                end
            end
            if ($urandom_range(0, 299) == 0) begin
                case ($urandom_range(0, 2))
                    0:       out_stall_pct = 0;
                    1:       out_stall_pct = 8;
                    default: out_stall_pct = 30;
                endcase
            end
            if (stall_left != 0 && !no_idle) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 99) < out_stall_pct) begin
                stall_left = $urandom_range(0, 8);
                out_stall <= 1'b1;
            end else begin
                stall_left = 0;
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge clk);
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_in_item it;
        clock_ms = 32'hFFFF_FFF0;
        tick_max = 4;
        jump_max = 80000;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // idle ticks at both ends of the time range, e-stop from idle
        it = base_item(OP_UPDATE);
        it.estop_active = 1'b0;
        it.now_ms = '0;
        pending_items.push_back(it);
        it = base_item(OP_UPDATE);
        it.estop_active = 1'b1;
        it.now_ms = '1;
        pending_items.push_back(it);
        // start while in error, bad pairings, cancel with cylinder out, cancel in idle
        pending_items.push_back(start_item(DIR_R1_TO_R2, DEST_CELL3, 3'b111, 1'b0, 4'b0001));
        pending_items.push_back(start_item(DIR_R1_TO_R2, DEST_CELL1, 3'b111, 1'b0, 4'b0001));
        it = base_item(OP_CANCEL);
        it.cylinder_position = 2'b01;
        pending_items.push_back(it);
        pending_items.push_back(base_item(OP_CANCEL));
        pending_items.push_back(start_item(DIR_R2_TO_R1, DEST_CELL3, 3'b111, 1'b0, 4'b1000));
        // not ready, e-stop at start, collisions, empty source, a clean start, reset
        pending_items.push_back(start_item(DIR_R1_TO_R2, DEST_CELL3, 3'b011, 1'b0, 4'b0001));
        pending_items.push_back(start_item(DIR_R1_TO_R2, DEST_CELL3, 3'b111, 1'b1, 4'b0001));
        pending_items.push_back(start_item(DIR_R1_TO_R2, DEST_CELL3, 3'b111, 1'b0, 4'b0101));
        pending_items.push_back(start_item(DIR_R2_TO_R1, DEST_STAGE_AREA, 3'b111, 1'b0,
                                           4'b1000));
        pending_items.push_back(start_item(DIR_R1_TO_R2, DEST_CELL3, 3'b111, 1'b0, 4'b0000));
        pending_items.push_back(start_item(DIR_R2_TO_R1, DEST_CELL1, 3'b111, 1'b0, 4'b0100));
        pending_items.push_back(base_item(OP_RESET));
        // a handoff across the time wrap
        queue_handoff();

        tick_max = 500;
        fill_random(380);
        drain();

        set_timeouts(1, 1, 1);
        tick_max = 1;
        jump_max = 4;
        fill_random(150);
        drain();

        set_timeouts(600000, 600000, 600000);
        tick_max = 5000;
        jump_max = 1500000;
        fill_random(200);
        drain();

        set_timeouts($urandom_range(20, 3000), $urandom_range(20, 3000), $urandom_range(20, 3000));
        tick_max = 100;
        jump_max = 5000;
        fill_random(350);
        drain();

        set_timeouts($urandom_range(1, 600000), $urandom_range(1, 600000),
                     $urandom_range(1, 600000));
        no_idle <= 1'b1;
        tick_max = 2000;
        jump_max = 70000;
        fill_random(250);
        drain();

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
